// ===== rtl/md5sd_pkg.sv =====
package md5sd_pkg;

	localparam logic [31:0] INIT_A = 32'h67452301;
	localparam logic [31:0] INIT_B = 32'hefcdab89;
	localparam logic [31:0] INIT_C = 32'h98badcfe;
	localparam logic [31:0] INIT_D = 32'h10325476;
	localparam logic [7:0]  PAD_BYTE = 8'h80;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_ROUND,
		ST_FOLD,
		ST_PAD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic start;
		logic done;
	} core_ctl_t;

	function automatic logic [31:0] md5_k(input logic [5:0] j);
		logic [31:0] r;
		begin
			unique case (j)
				6'd0: r = 32'hd76aa478; 6'd1: r = 32'he8c7b756; 6'd2: r = 32'h242070db;
				6'd3: r = 32'hc1bdceee; 6'd4: r = 32'hf57c0faf; 6'd5: r = 32'h4787c62a;
				6'd6: r = 32'ha8304613; 6'd7: r = 32'hfd469501; 6'd8: r = 32'h698098d8;
				6'd9: r = 32'h8b44f7af; 6'd10: r = 32'hffff5bb1; 6'd11: r = 32'h895cd7be;
				6'd12: r = 32'h6b901122; 6'd13: r = 32'hfd987193; 6'd14: r = 32'ha679438e;
				6'd15: r = 32'h49b40821; 6'd16: r = 32'hf61e2562; 6'd17: r = 32'hc040b340;
				6'd18: r = 32'h265e5a51; 6'd19: r = 32'he9b6c7aa; 6'd20: r = 32'hd62f105d;
				6'd21: r = 32'h02441453; 6'd22: r = 32'hd8a1e681; 6'd23: r = 32'he7d3fbc8;
				6'd24: r = 32'h21e1cde6; 6'd25: r = 32'hc33707d6; 6'd26: r = 32'hf4d50d87;
				6'd27: r = 32'h455a14ed; 6'd28: r = 32'ha9e3e905; 6'd29: r = 32'hfcefa3f8;
				6'd30: r = 32'h676f02d9; 6'd31: r = 32'h8d2a4c8a; 6'd32: r = 32'hfffa3942;
				6'd33: r = 32'h8771f681; 6'd34: r = 32'h6d9d6122; 6'd35: r = 32'hfde5380c;
				6'd36: r = 32'ha4beea44; 6'd37: r = 32'h4bdecfa9; 6'd38: r = 32'hf6bb4b60;
				6'd39: r = 32'hbebfbc70; 6'd40: r = 32'h289b7ec6; 6'd41: r = 32'heaa127fa;
				6'd42: r = 32'hd4ef3085; 6'd43: r = 32'h04881d05; 6'd44: r = 32'hd9d4d039;
				6'd45: r = 32'he6db99e5; 6'd46: r = 32'h1fa27cf8; 6'd47: r = 32'hc4ac5665;
				6'd48: r = 32'hf4292244; 6'd49: r = 32'h432aff97; 6'd50: r = 32'hab9423a7;
				6'd51: r = 32'hfc93a039; 6'd52: r = 32'h655b59c3; 6'd53: r = 32'h8f0ccc92;
				6'd54: r = 32'hffeff47d; 6'd55: r = 32'h85845dd1; 6'd56: r = 32'h6fa87e4f;
				6'd57: r = 32'hfe2ce6e0; 6'd58: r = 32'ha3014314; 6'd59: r = 32'h4e0811a1;
				6'd60: r = 32'hf7537e82; 6'd61: r = 32'hbd3af235; 6'd62: r = 32'h2ad7d2bb;
				default: r = 32'heb86d391;
			endcase
			return r;
		end
	endfunction

	function automatic logic [4:0] md5_rot(input logic [5:0] j);
		logic [4:0] r;
		begin
			unique case ({j[5:4], j[1:0]})
				4'd0: r = 5'd7;   4'd1: r = 5'd12;  4'd2: r = 5'd17;  4'd3: r = 5'd22;
				4'd4: r = 5'd5;   4'd5: r = 5'd9;   4'd6: r = 5'd14;  4'd7: r = 5'd20;
				4'd8: r = 5'd4;   4'd9: r = 5'd11;  4'd10: r = 5'd16; 4'd11: r = 5'd23;
				4'd12: r = 5'd6;  4'd13: r = 5'd10; 4'd14: r = 5'd15; default: r = 5'd21;
			endcase
			return r;
		end
	endfunction

	function automatic logic [3:0] md5_g(input logic [5:0] j);
		logic [3:0] r;
		begin
			unique case (j[5:4])
				2'd0: r = j[3:0];
				2'd1: r = 4'(5 * j[3:0] + 1);
				2'd2: r = 4'(3 * j[3:0] + 5);
				default: r = 4'(7 * j[3:0]);
			endcase
			return r;
		end
	endfunction

endpackage

// ===== rtl/md5sd_stream_if.sv =====
interface md5sd_stream_if #(parameter int W = 32);
	logic         valid;
	logic         ready;
	logic [W-1:0] payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

// ===== rtl/md5sd_ram.sv =====
module md5sd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/md5sd_core.sv =====
module md5sd_core import md5sd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] msg_word,
	output logic [3:0]  msg_addr,
	output logic        done,
	input  logic        clear,
	output logic [31:0] chain [4]
);
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic [31:0] f, sum, rot;
	logic [5:0]  j, jn;
	logic [4:0]  sh;

	assign j  = cnt_q[5:0] - 6'd1;
	assign jn = cnt_q[5:0];
	assign msg_addr = start ? md5_g(6'd0) : md5_g(jn);

	always_comb begin
		unique case (j[5:4])
			2'd0: f = (b_q & c_q) | (~b_q & d_q);
			2'd1: f = (d_q & b_q) | (~d_q & c_q);
			2'd2: f = b_q ^ c_q ^ d_q;
			default: f = c_q ^ (b_q | ~d_q);
		endcase
		sum = f + a_q + md5_k(j) + msg_word;
		sh  = md5_rot(j);
		rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
	end

	assign done = busy_q && cnt_q == 7'd64;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			chain[0] <= INIT_A; chain[1] <= INIT_B;
			chain[2] <= INIT_C; chain[3] <= INIT_D;
		end else if (clear) begin
			chain[0] <= INIT_A; chain[1] <= INIT_B;
			chain[2] <= INIT_C; chain[3] <= INIT_D;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
			a_q <= chain[0]; b_q <= chain[1]; c_q <= chain[2]; d_q <= chain[3];
		end else if (busy_q) begin
			if (cnt_q == 7'd64) begin
				busy_q <= 1'b0;
				chain[0] <= chain[0] + d_q;
				chain[1] <= chain[1] + b_q + rot;
				chain[2] <= chain[2] + b_q;
				chain[3] <= chain[3] + c_q;
			end else begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q != 7'd0) begin
					a_q <= d_q; d_q <= c_q; c_q <= b_q; b_q <= b_q + rot;
				end
			end
		end
	end
endmodule

// ===== rtl/md5_stream_digest_top.sv =====
// MD5 of a byte stream sent as little-endian 32-bit words. Each word is
// written into a 16-entry block RAM; when a block fills, one shared round
// unit runs the 64 rounds, one a cycle. Load, first-word fetch, rounds and
// chaining add keep in.ready low, so no word is taken until the block is
// compressed. A last word adds padding words one a cycle and one or two more
// blocks, then the four digest words A to D are sent with word_index and
// last_word on D. in.ready is low while a block compresses, while padding,
// and while the digest is sent.
module md5_stream_digest_top import md5sd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	md5sd_stream_if.sink   in,
	md5sd_stream_if.source out
);
	state_t      state_q, state_d;
	logic [3:0]  fill_q;
	logic [63:0] bits_q;
	logic        pad_q, two_q, padsent_q, last_blk_q;
	logic [1:0]  idx_q;
	logic        we, start, done, clear;
	logic [3:0]  waddr, raddr, maddr;
	logic [31:0] wdata, rdata, wmask;
	logic [31:0] chain [4];
	logic [31:0] dw;
	logic [2:0]  bc, bn;
	logic        lst, acc;

	assign dw  = in.payload[31:0];
	assign bc  = in.payload[34:32];
	assign lst = in.payload[35];
	assign bn  = (bc > 3'd4) ? 3'd4 : bc;
	assign acc = in.valid && in.ready;
	assign in.ready = state_q == ST_IDLE;

	md5sd_ram #(.WIDTH(32), .DEPTH(16)) u_buf (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	md5sd_core u_core (
		.clk(clk), .arst_n(arst_n), .start(start), .msg_word(rdata),
		.msg_addr(maddr), .done(done), .clear(clear), .chain(chain)
	);
	assign raddr = maddr;

	always_comb begin
		wmask = 32'hffffffff >> (6'd32 - {bn, 3'b000});
		if (bn == 3'd0) wmask = '0;
		we = 1'b0; waddr = fill_q; wdata = dw;
		if (acc) begin
			we = 1'b1;
			if (lst && bn != 3'd4) begin
				wdata = (dw & wmask) | (32'(PAD_BYTE) << {bn[1:0], 3'b000});
			end
		end else if (state_q == ST_PAD) begin
			we = 1'b1;
			priority if (!padsent_q) wdata = 32'(PAD_BYTE);
			else if (!two_q && fill_q == 4'd14) wdata = bits_q[31:0];
			else if (!two_q && fill_q == 4'd15) wdata = bits_q[63:32];
			else wdata = '0;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (acc) begin
				if (fill_q == 4'd15) state_d = ST_INIT;
				else if (lst) state_d = ST_PAD;
			end
			ST_INIT: state_d = ST_ROUND;
			ST_ROUND: if (done) state_d = ST_FOLD;
			ST_FOLD: state_d = pad_q ? (fill_q == 4'd0 && !two_q && padsent_q
				&& last_blk_q ? ST_EMIT : ST_PAD) : ST_IDLE;
			ST_PAD: if (fill_q == 4'd15) state_d = ST_INIT;
			ST_EMIT: if (out.ready && idx_q == 2'd3) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	assign start = state_q == ST_INIT;
	assign clear = state_q == ST_EMIT && out.ready && idx_q == 2'd3;

	always_comb begin
		out.valid = state_q == ST_EMIT;
		out.payload = {idx_q == 2'd3, idx_q, chain[idx_q]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q <= '0; bits_q <= '0; pad_q <= 1'b0; two_q <= 1'b0;
			padsent_q <= 1'b0; idx_q <= '0; last_blk_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (acc) begin
				fill_q <= fill_q + 4'd1;
				if (lst) begin
					bits_q <= bits_q + 64'({bn, 3'b000});
					pad_q <= 1'b1;
					padsent_q <= bn != 3'd4;
					two_q <= (bn == 3'd4) ? fill_q >= 4'd13 : fill_q >= 4'd14;
				end else begin
					bits_q <= bits_q + 64'd32;
				end
			end
			if (state_q == ST_PAD) begin
				fill_q <= fill_q + 4'd1;
				padsent_q <= 1'b1;
				if (fill_q == 4'd15) last_blk_q <= !two_q;
			end
			if (state_q == ST_FOLD && pad_q) two_q <= 1'b0;
			if (state_q == ST_EMIT && out.ready) begin
				idx_q <= idx_q + 2'd1;
				if (idx_q == 2'd3) begin
					fill_q <= '0; bits_q <= '0; pad_q <= 1'b0;
					two_q <= 1'b0; padsent_q <= 1'b0; last_blk_q <= 1'b0;
				end
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> state_q == ST_ROUND)
		else $error("round done outside compression");
	assert property (@(posedge clk) disable iff (!arst_n)
		out.valid |-> !in.ready)
		else $error("input open during digest");
	assert property (@(posedge clk) disable iff (!arst_n)
		start |=> state_q == ST_ROUND)
		else $error("compression not started");
endmodule
